@@ src/sle_pkg.sv @@
// Shared types and constants for the sequential list engine.
// Used by the controller, the datapath and the top level; depends on nothing.
package sle_pkg;

  localparam int DEPTH_DEFAULT = 128;
  localparam int OP_W          = 2;
  localparam int POS_W         = 8;
  localparam int DATA_W        = 32;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LOCATE = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_INS_CHK,
    ST_INS_WR,
    ST_DEL_CAP,
    ST_DEL_CHK,
    ST_DEL_WR,
    ST_SCAN_CHK,
    ST_SCAN_CMP,
    ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    PTR_HOLD,
    PTR_COUNT,
    PTR_POS,
    PTR_ZERO,
    PTR_INC,
    PTR_DEC
  } ptr_op_t;

  typedef enum logic [1:0] {
    ADDR_PTR,
    ADDR_PTR_M1,
    ADDR_POS_M1
  } addr_sel_t;

  typedef enum logic {
    WSRC_READ,
    WSRC_VALUE
  } wr_src_t;

  typedef struct packed {
    logic      load_item;
    ptr_op_t   ptr_op;
    logic      rd_en;
    addr_sel_t rd_sel;
    logic      wr_en;
    addr_sel_t wr_sel;
    wr_src_t   wr_src;
    logic      count_inc;
    logic      count_dec;
    logic      set_ok;
    logic      capture_removed;
    logic      capture_found;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            ins_valid;
    logic            del_valid;
    logic            ptr_ge_pos;
    logic            ptr_lt_count;
    logic            match;
    logic            out_free;
  } status_t;

endpackage

@@ src/sle_if.sv @@
// Handshake interfaces for the request and response channels.
// Self-contained; widths match the field widths in sle_pkg.
interface sle_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [7:0]         position;
  logic signed [31:0] element_value;

  modport source (output valid, output opcode, output position, output element_value,
                  input ready);
  modport sink   (input valid, input opcode, input position, input element_value,
                  output ready);
endinterface

interface sle_rsp_if;
  logic               valid;
  logic               ready;
  logic               ok;
  logic signed [31:0] removed_value;
  logic [7:0]         found_position;
  logic [7:0]         list_length;

  modport source (output valid, output ok, output removed_value, output found_position,
                  output list_length, input ready);
  modport sink   (input valid, input ok, input removed_value, input found_position,
                  input list_length, output ready);
endinterface

@@ src/sequential_list_engine_core.sv @@
// Top level of the sequential list engine: controller plus datapath.
// Depends on sle_pkg, sle_if.sv, sle_ctrl and sle_dp.
//
//   Channel  Dir   Beat contents
//   -------  ----  ----------------------------------------------------
//   req      in    opcode, position, element_value (one operation)
//   rsp      out   ok, removed_value, found_position, list_length
//
// One request beat at a time is worked on. An insert shifts the elements from
// the tail down to its position one place up, a delete shifts the elements
// behind its position one place down, and a locate compares the elements
// from the head until the first match or the end of the list; a rejected or
// unused operation moves nothing. The pace is set by the registered read of
// the element memory: every moved element needs one read and one write, and a
// search waits for each registered read before it compares it.
// Reset is synchronous and clears the length, the controller and the
// response valid; the element memory is not cleared, since only entries
// below the length are ever read. No request beat is taken while reset is
// held. The response sits in an output register,
// so a new request beat is taken while the last response still waits; a
// finished operation holds in its final state until that register is free.
module sequential_list_engine_core #(
  parameter int DEPTH = sle_pkg::DEPTH_DEFAULT
) (
  input logic      clk,
  input logic      rst,
  sle_req_if.sink   req,
  sle_rsp_if.source rsp
);
  import sle_pkg::*;

  // Command and status between the state machine and the datapath.
  cmd_t    cmd;
  status_t status;

  sle_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .status    (status),
    .cmd       (cmd)
  );

  sle_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .status             (status),
    .req_opcode         (req.opcode),
    .req_position       (req.position),
    .req_element_value  (req.element_value),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_ok             (rsp.ok),
    .rsp_removed_value  (rsp.removed_value),
    .rsp_found_position (rsp.found_position),
    .rsp_list_length    (rsp.list_length)
  );

endmodule

@@ src/sle_ctrl.sv @@
// Controller state machine for the sequential list engine.
// Depends on sle_pkg for the state, command and status types.
module sle_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_ready,
  input  sle_pkg::status_t status,
  output sle_pkg::cmd_t    cmd
);
  import sle_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        unique case (status.op)
          OP_INSERT: state_next = status.ins_valid ? ST_INS_CHK : ST_FINISH;
          OP_DELETE: state_next = status.del_valid ? ST_DEL_CAP : ST_FINISH;
          OP_LOCATE: state_next = ST_SCAN_CHK;
          default:   state_next = ST_FINISH;
        endcase
      end
      ST_INS_CHK:  state_next = status.ptr_ge_pos ? ST_INS_WR : ST_FINISH;
      ST_INS_WR:   state_next = ST_INS_CHK;
      ST_DEL_CAP:  state_next = ST_DEL_CHK;
      ST_DEL_CHK:  state_next = status.ptr_lt_count ? ST_DEL_WR : ST_FINISH;
      ST_DEL_WR:   state_next = ST_DEL_CHK;
      ST_SCAN_CHK: state_next = status.ptr_lt_count ? ST_SCAN_CMP : ST_FINISH;
      ST_SCAN_CMP: state_next = status.match ? ST_FINISH : ST_SCAN_CHK;
      ST_FINISH: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.ptr_op = PTR_HOLD;
    cmd.rd_sel = ADDR_PTR;
    cmd.wr_sel = ADDR_PTR;
    cmd.wr_src = WSRC_READ;
    req_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        // No beat is taken while reset is held.
        req_ready     = !rst;
        cmd.load_item = req_valid && !rst;
      end
      ST_DISPATCH: begin
        unique case (status.op)
          OP_INSERT: begin
            if (status.ins_valid) cmd.ptr_op = PTR_COUNT;
          end
          OP_DELETE: begin
            if (status.del_valid) begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = ADDR_POS_M1;
              cmd.ptr_op = PTR_POS;
            end
          end
          OP_LOCATE: cmd.ptr_op = PTR_ZERO;
          default: ;
        endcase
      end
      ST_INS_CHK: begin
        if (status.ptr_ge_pos) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ADDR_PTR_M1;
        end else begin
          cmd.wr_en     = 1'b1;
          cmd.wr_sel    = ADDR_POS_M1;
          cmd.wr_src    = WSRC_VALUE;
          cmd.count_inc = 1'b1;
          cmd.set_ok    = 1'b1;
        end
      end
      ST_INS_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = ADDR_PTR;
        cmd.ptr_op = PTR_DEC;
      end
      ST_DEL_CAP: cmd.capture_removed = 1'b1;
      ST_DEL_CHK: begin
        if (status.ptr_lt_count) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ADDR_PTR;
        end else begin
          cmd.count_dec = 1'b1;
        end
      end
      ST_DEL_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = ADDR_PTR_M1;
        cmd.ptr_op = PTR_INC;
      end
      ST_SCAN_CHK: begin
        if (status.ptr_lt_count) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ADDR_PTR;
        end
      end
      ST_SCAN_CMP: begin
        if (status.match) begin
          cmd.capture_found = 1'b1;
        end else begin
          cmd.ptr_op = PTR_INC;
        end
      end
      ST_FINISH: cmd.out_load = status.out_free;
      default: ;
    endcase
  end

endmodule

@@ src/sle_dp.sv @@
// Datapath for the sequential list engine: element memory, pointer, count,
// result registers and the output register. Depends on sle_pkg.
module sle_dp #(
  parameter int DEPTH = sle_pkg::DEPTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  sle_pkg::cmd_t      cmd,
  output sle_pkg::status_t   status,
  input  logic [1:0]         req_opcode,
  input  logic [7:0]         req_position,
  input  logic signed [31:0] req_element_value,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output logic               rsp_ok,
  output logic signed [31:0] rsp_removed_value,
  output logic [7:0]         rsp_found_position,
  output logic [7:0]         rsp_list_length
);
  import sle_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  // Compare width: holds both the position field and the count, plus one.
  localparam int PW = ((CW > POS_W) ? CW : POS_W) + 1;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data;

  logic [OP_W-1:0]   op_q;
  logic [POS_W-1:0]  pos_q;
  logic [DATA_W-1:0] val_q;
  logic [CW-1:0]     count;
  logic [CW-1:0]     ptr;

  logic              res_ok;
  logic [DATA_W-1:0] res_removed;
  logic [POS_W-1:0]  res_found;

  logic [PW-1:0]     pos_x;
  logic [PW-1:0]     ptr_x;
  logic [PW-1:0]     count_x;
  logic [PW-1:0]     pos_m1_x;
  logic [PW-1:0]     ptr_m1_x;
  logic [PW-1:0]     ptr_p1_x;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic [DATA_W-1:0] wr_data;

  assign pos_x    = {{(PW-POS_W){1'b0}}, pos_q};
  assign ptr_x    = {{(PW-CW){1'b0}}, ptr};
  assign count_x  = {{(PW-CW){1'b0}}, count};
  assign pos_m1_x = pos_x - 1'b1;
  assign ptr_m1_x = ptr_x - 1'b1;
  assign ptr_p1_x = ptr_x + 1'b1;

  always_comb begin
    status.op           = op_q;
    status.ins_valid    = (pos_q != '0) && (pos_x <= count_x + 1'b1)
                          && (count < CW'(DEPTH));
    status.del_valid    = (pos_q != '0) && (pos_x <= count_x);
    status.ptr_ge_pos   = (ptr_x >= pos_x);
    status.ptr_lt_count = (ptr < count);
    status.match        = (rd_data == val_q);
    status.out_free     = !rsp_valid || rsp_ready;
  end

  always_comb begin
    unique case (cmd.rd_sel)
      ADDR_PTR:    rd_addr = ptr_x[AW-1:0];
      ADDR_PTR_M1: rd_addr = ptr_m1_x[AW-1:0];
      ADDR_POS_M1: rd_addr = pos_m1_x[AW-1:0];
      default:     rd_addr = ptr_x[AW-1:0];
    endcase
    unique case (cmd.wr_sel)
      ADDR_PTR:    wr_addr = ptr_x[AW-1:0];
      ADDR_PTR_M1: wr_addr = ptr_m1_x[AW-1:0];
      ADDR_POS_M1: wr_addr = pos_m1_x[AW-1:0];
      default:     wr_addr = ptr_x[AW-1:0];
    endcase
    wr_data = (cmd.wr_src == WSRC_VALUE) ? val_q : rd_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_q  <= req_opcode;
      pos_q <= req_position;
      val_q <= req_element_value;
    end
    unique case (cmd.ptr_op)
      PTR_HOLD:  ptr <= ptr;
      PTR_COUNT: ptr <= count;
      PTR_POS:   ptr <= pos_x[CW-1:0];
      PTR_ZERO:  ptr <= '0;
      PTR_INC:   ptr <= ptr_p1_x[CW-1:0];
      PTR_DEC:   ptr <= ptr_m1_x[CW-1:0];
      default:   ptr <= ptr;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.count_inc) begin
      count <= count + 1'b1;
    end else if (cmd.count_dec) begin
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      res_ok      <= 1'b0;
      res_removed <= '0;
      res_found   <= '0;
    end else begin
      if (cmd.set_ok) begin
        res_ok <= 1'b1;
      end
      if (cmd.capture_removed) begin
        res_ok      <= 1'b1;
        res_removed <= rd_data;
      end
      if (cmd.capture_found) begin
        res_ok    <= 1'b1;
        res_found <= ptr_p1_x[POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      rsp_ok             <= res_ok;
      rsp_removed_value  <= res_removed;
      rsp_found_position <= res_found;
      rsp_list_length    <= count_x[POS_W-1:0];
    end
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// Testbench for sequential_list_engine_core: sends list operations on the request channel
// and checks every response beat against a queue-based list model held here.
// Depends on sle_pkg, sle_if.sv and the core RTL.
module tb;
  import sle_pkg::*;

  localparam int LIST_DEPTH = 128;
  // The opcode that the block answers without touching the list.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  // The slowest correct run stays far below this, even with every stall at its longest.
  localparam int CYCLE_LIMIT = 2_000_000;
  // The longest operation is a full-length shift or search; settling lasts well beyond it.
  localparam int SETTLE_CYCLES = 600;

  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] removed_value;
    logic [POS_W-1:0]  found_position;
    logic [POS_W-1:0]  list_length;
  } list_result_t;

  logic clk;
  logic rst;

  sle_req_if req_ch();
  sle_rsp_if rsp_ch();

  sequential_list_engine_core #(
    .DEPTH(LIST_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // The list as the block should hold it, and the responses still owed, oldest first.
  logic signed [DATA_W-1:0] list_model[$];
  list_result_t             pending_results[$];

  int          mismatch_count  = 0;
  int unsigned cycle_count     = 0;
  // While quiet_mode is set neither side inserts random gaps or stalls.
  bit          quiet_mode      = 1'b0;
  // A nonzero value asks the response side for one hold-off of that length.
  int          rsp_hold_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Gap lengths: mostly none, often short, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (quiet_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Element values: small ones make duplicates likely, so that the search has to
  // report the first match; the two extremes and full random values cover every bit.
  function automatic logic signed [DATA_W-1:0] random_value();
    case ($urandom_range(0, 5))
      0, 1:    return $urandom_range(0, 7);
      2:       return 32'sh8000_0000;
      3:       return 32'sh7FFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // A position at or above first_bad is out of range; position zero always is.
  function automatic logic [POS_W-1:0] bad_position(input int first_bad);
    if (first_bad > 255 || $urandom_range(0, 2) == 0) return '0;
    return POS_W'($urandom_range(first_bad, 255));
  endfunction

  // Applies one operation to the model list and returns the response it must produce.
  function automatic list_result_t apply_list_op(input logic [OP_W-1:0] op,
                                                 input logic [POS_W-1:0] pos,
                                                 input logic signed [DATA_W-1:0] value);
    list_result_t res;
    int len;
    len = list_model.size();
    res = '0;
    case (op)
      OP_INSERT: begin
        if (pos >= 1 && pos <= len + 1 && len < LIST_DEPTH) begin
          list_model.insert(pos - 1, value);
          res.ok = 1'b1;
        end
      end
      OP_DELETE: begin
        if (pos >= 1 && pos <= len) begin
          res.removed_value = list_model[pos - 1];
          list_model.delete(pos - 1);
          res.ok = 1'b1;
        end
      end
      OP_LOCATE: begin
        // Only the first match counts; later equal values leave the result alone.
        for (int k = 0; k < len; k++) begin
          if (!res.ok && list_model[k] == value) begin
            res.found_position = POS_W'(k + 1);
            res.ok = 1'b1;
          end
        end
      end
      default: ;
    endcase
    res.list_length = POS_W'(list_model.size());
    return res;
  endfunction

  // Offers one request beat and records its response once the beat is taken.
  // Valid stays high after the beat so that back-to-back beats need no idle time;
  // a later call lowers it only to insert a gap, and wait_for_drain lowers it.
  task automatic send_op(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                         input logic signed [DATA_W-1:0] value);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.opcode        <= op;
    req_ch.position      <= pos;
    req_ch.element_value <= value;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    pending_results.push_back(apply_list_op(op, pos, value));
  endtask

  // Stops offering beats and waits until every owed response has come back.
  task automatic wait_for_drain();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // One random operation. Most positions are legal so that the list actually
  // grows and shrinks; max_len steers the length so that shifts stay short.
  task automatic send_random_op(input int max_len);
    int len;
    int r;
    int ins_pct;
    logic [OP_W-1:0] op;
    logic [POS_W-1:0] pos;
    logic signed [DATA_W-1:0] value;
    len     = list_model.size();
    r       = $urandom_range(0, 99);
    ins_pct = (len >= max_len) ? 15 : 45;
    value   = random_value();
    pos     = POS_W'($urandom_range(0, 255));
    if (r < 5) begin
      op = OP_UNUSED;
    end else if (r < 5 + ins_pct) begin
      op  = OP_INSERT;
      pos = ($urandom_range(0, 9) == 0) ? bad_position(len + 2)
                                        : POS_W'($urandom_range(1, len + 1));
    end else if (r < 75) begin
      op  = OP_DELETE;
      pos = (len == 0 || $urandom_range(0, 9) == 0) ? bad_position(len + 1)
                                                    : POS_W'($urandom_range(1, len));
    end else begin
      op = OP_LOCATE;
      if (len > 0 && $urandom_range(0, 3) != 0) value = list_model[$urandom_range(0, len - 1)];
    end
    send_op(op, pos, value);
  endtask

  // Directed part on an empty list: the rejections by position, inserts at head, middle
  // and tail, a duplicate value, searches that hit and miss, the unused opcode,
  // and deletes from tail, head and middle down to empty again.
  task automatic test_directed_cases();
    send_op(OP_DELETE, 8'd1, 32'sd0);               // delete from an empty list
    send_op(OP_LOCATE, 8'd0, 32'sd5);               // search an empty list
    send_op(OP_INSERT, 8'd0, 32'sd1);               // position zero
    send_op(OP_INSERT, 8'd2, 32'sd1);               // past length plus one
    send_op(OP_INSERT, 8'd255, 32'sd1);
    send_op(OP_INSERT, 8'd1, 32'sh7FFF_FFFF);
    send_op(OP_INSERT, 8'd1, 32'sh8000_0000);       // new head
    send_op(OP_INSERT, 8'd3, -32'sd1);              // append at the tail
    send_op(OP_INSERT, 8'd2, 32'sd0);               // into the middle
    send_op(OP_INSERT, 8'd6, 32'sd9);               // two past the end
    send_op(OP_INSERT, 8'd5, 32'sd0);               // duplicate value at the tail
    send_op(OP_LOCATE, 8'd0, 32'sd0);               // first of two matches
    send_op(OP_LOCATE, 8'd255, 32'sh8000_0000);     // position is ignored
    send_op(OP_LOCATE, 8'd3, -32'sd1);
    send_op(OP_LOCATE, 8'd0, 32'sd12345);           // absent value
    send_op(OP_UNUSED, 8'd255, -32'sd1);
    send_op(OP_DELETE, 8'd0, 32'sd0);
    send_op(OP_DELETE, 8'd6, 32'sd0);               // one past the length
    send_op(OP_DELETE, 8'd255, -32'sd1);
    send_op(OP_DELETE, 8'd5, 32'sd0);               // tail
    send_op(OP_DELETE, 8'd1, 32'sd0);               // head
    send_op(OP_DELETE, 8'd2, 32'sd0);               // middle
    send_op(OP_DELETE, 8'd2, 32'sd0);
    send_op(OP_DELETE, 8'd1, 32'sd0);               // back to empty
  endtask

  // Fills the list to capacity at random positions, checks that a full list
  // refuses inserts, then empties it again with searches mixed in.
  task automatic test_fill_and_empty();
    while (list_model.size() < LIST_DEPTH)
      send_op(OP_INSERT, POS_W'($urandom_range(1, list_model.size() + 1)), random_value());
    send_op(OP_INSERT, 8'd1, random_value());
    send_op(OP_INSERT, POS_W'(LIST_DEPTH + 1), random_value());
    send_op(OP_INSERT, 8'd255, random_value());
    send_op(OP_LOCATE, 8'd0, list_model[LIST_DEPTH - 1]);
    send_op(OP_DELETE, POS_W'(LIST_DEPTH + 1), 32'sd0);
    send_op(OP_DELETE, POS_W'(LIST_DEPTH), 32'sd0);
    while (list_model.size() > 0) begin
      if ($urandom_range(0, 4) == 0)
        send_op(OP_LOCATE, POS_W'($urandom_range(0, 255)),
                list_model[$urandom_range(0, list_model.size() - 1)]);
      else
        send_op(OP_DELETE, POS_W'($urandom_range(1, list_model.size())), random_value());
    end
  endtask

  // The response side holds off for a long stretch while beats keep coming, so
  // the output register and the operation in flight both fill and the request
  // side has to stall.
  task automatic test_output_backpressure();
    quiet_mode = 1'b1;
    wait_for_drain();
    rsp_hold_cycles = 400;
    repeat (10) send_random_op(32);
    quiet_mode = 1'b0;
  endtask

  // Random operations in phases. Some phases run without any gaps, some let the
  // list grow long; every second phase ends with a full drain before the next starts.
  task automatic test_random_ops();
    for (int phase = 0; phase < 12; phase++) begin
      quiet_mode = (phase % 4 == 3);
      repeat (50) send_random_op((phase % 3 == 0) ? 100 : 24);
      if (phase % 2 == 1) wait_for_drain();
    end
    quiet_mode = 1'b0;
  endtask

  // Response side: ready mostly high, with random stalls and, when asked, one
  // long hold-off counted here.
  initial begin : rsp_ready_driver
    int n;
    rsp_ch.ready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (rsp_hold_cycles > 0) begin
        n = rsp_hold_cycles;
        rsp_hold_cycles = 0;
        rsp_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        n = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
        if (n > 0) begin
          rsp_ch.ready <= 1'b0;
          repeat (n) @(posedge clk);
        end else begin
          rsp_ch.ready <= 1'b1;
          @(posedge clk);
        end
      end
    end
  end

  // Every response beat is compared field by field with the oldest owed response.
  always @(posedge clk) begin : rsp_check
    list_result_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("response beat with no operation outstanding");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (rsp_ch.ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, rsp_ch.ok);
          mismatch_count++;
        end
        if (rsp_ch.removed_value !== want.removed_value) begin
          $error("removed_value: expected %0d, got %0d",
                 $signed(want.removed_value), $signed(rsp_ch.removed_value));
          mismatch_count++;
        end
        if (rsp_ch.found_position !== want.found_position) begin
          $error("found_position: expected %0d, got %0d",
                 want.found_position, rsp_ch.found_position);
          mismatch_count++;
        end
        if (rsp_ch.list_length !== want.list_length) begin
          $error("list_length: expected %0d, got %0d", want.list_length, rsp_ch.list_length);
          mismatch_count++;
        end
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sequential_list_engine_core test failed");
      $finish;
    end
  end

  initial begin
    rst                  = 1'b1;
    req_ch.valid         = 1'b0;
    req_ch.opcode        = OP_INSERT;
    req_ch.position      = '0;
    req_ch.element_value = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_cases();
    test_fill_and_empty();
    test_output_backpressure();
    test_random_ops();

    // Let everything owed come back, then watch a while for stray beats.
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("sequential_list_engine_core test passed");
    else
      $display("sequential_list_engine_core test failed");
    $finish;
  end

endmodule
